[src/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator core.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int unsigned ARENA_BYTES      = 1048576;
    localparam int unsigned HEADER_BYTES     = 48;
    localparam int unsigned MAX_BLOCKS_DEF   = 64;
    localparam int unsigned ALIGN_BYTES      = 16;
    localparam int unsigned MIN_USEFUL_RESET = 32;

    localparam int unsigned ADDR_W = 21;
    localparam int unsigned NEED_W = ADDR_W + 1;
    localparam int unsigned CFG_W  = 11;
    localparam int unsigned THR_W  = 12;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned STAT_W = 3;

    localparam logic [ADDR_W-1:0] HDR_ADDR  = ADDR_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] HDR_NEED  = NEED_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] ALIGN_MSK = NEED_W'(ALIGN_BYTES - 1);

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_OOM     = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic              vld;
        logic              is_free;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] bytes;
    } t_entry;

    localparam t_entry ENTRY_INIT = '{
        vld:     1'b1,
        is_free: 1'b1,
        start:   '0,
        bytes:   ADDR_W'(ARENA_BYTES - HEADER_BYTES)
    };

    typedef struct packed {
        t_cmd              cmd;
        logic [NEED_W-1:0] need;
        logic [NEED_W-1:0] need_h;
        logic [ADDR_W-1:0] faddr;
        logic [THR_W-1:0]  thr;
        logic              room;
    } t_req;

    typedef struct packed {
        logic              split;
        logic              merge;
        logic              take;
        logic              give;
        logic [ADDR_W-1:0] amount;
    } t_evt;

    typedef struct packed {
        logic              found;
        logic              dbl;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] granted;
    } t_info;

endpackage

[src/ffha_cell.sv]
// ----------------------------------------------------------------------------
// ffha_cell
// One slot of the block table ring; loads its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module ffha_cell
    import ffha_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_d,
    output t_entry o_q
);

    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            if (IS_HEAD) begin
                r_q <= ENTRY_INIT;
            end else begin
                r_q.vld <= 1'b0;
            end
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

[src/ffha_proc.sv]
// ----------------------------------------------------------------------------
// ffha_proc
// Processing stage of the ring: first-fit search, split, free and merge,
// with a two-entry pending buffer that absorbs inserted and removed entries.
// ----------------------------------------------------------------------------
module ffha_proc
    import ffha_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_scan,
    input  logic   i_shift,
    input  t_req   i_req,
    input  t_entry i_e,
    output t_entry o_out,
    output t_evt   o_evt,
    output t_info  o_info,
    output logic   o_pend
);

    t_entry r_p, r_q, n_p, n_q;
    t_info  r_info, n_info;
    logic   r_merge_next, n_merge_next;

    t_entry            w_tail, w_m0, w_m1, w_n0, w_n1, w_l0, w_l1, w_l2, w_split_e;
    logic              w_act, w_fit, w_split, w_hit_a, w_hit_f, w_merge_pred;
    logic              w_merge_succ, w_merge;
    logic [NEED_W-1:0] w_rest;
    logic [ADDR_W-1:0] w_sum;

    assign w_act   = i_scan && i_e.vld;
    assign w_tail  = r_q.vld ? r_q : r_p;
    assign w_fit   = i_e.is_free && ({1'b0, i_e.bytes} >= i_req.need);
    assign w_rest  = {1'b0, i_e.bytes} - i_req.need;
    assign w_split = (w_rest > NEED_W'(i_req.thr)) && i_req.room;
    assign w_hit_a = w_act && (i_req.cmd == CMD_ALLOC) && !r_info.found && w_fit;
    assign w_hit_f = w_act && (i_req.cmd == CMD_FREE) && !r_info.found
                     && ((i_e.start + HDR_ADDR) == i_req.faddr);
    assign w_merge_pred = w_hit_f && !i_e.is_free && r_p.vld && w_tail.is_free;
    assign w_merge_succ = w_act && r_merge_next && i_e.is_free;
    assign w_merge = w_merge_pred || w_merge_succ;
    assign w_sum   = w_tail.bytes + i_e.bytes + HDR_ADDR;

    assign w_split_e = '{
        vld:     1'b1,
        is_free: 1'b1,
        start:   i_e.start + i_req.need_h[ADDR_W-1:0],
        bytes:   w_rest[ADDR_W-1:0] - HDR_ADDR
    };

    always_comb begin
        w_m0 = r_p;
        w_m1 = r_q;
        if (w_merge) begin
            if (r_q.vld) begin
                w_m1.bytes = w_sum;
            end else begin
                w_m0.bytes = w_sum;
            end
        end

        w_n0 = i_e;
        w_n1 = '0;
        if (i_scan) begin
            priority if (w_merge) begin
                w_n0 = '0;
            end else if (w_hit_a) begin
                w_n0.is_free = 1'b0;
                if (w_split) begin
                    w_n0.bytes = i_req.need[ADDR_W-1:0];
                    w_n1       = w_split_e;
                end
            end else if (w_hit_f) begin
                w_n0.is_free = 1'b1;
            end
        end

        priority if (!w_m0.vld) begin
            w_l0 = w_n0;
            w_l1 = w_n1;
            w_l2 = '0;
        end else if (!w_m1.vld) begin
            w_l0 = w_m0;
            w_l1 = w_n0;
            w_l2 = w_n1;
        end else begin
            w_l0 = w_m0;
            w_l1 = w_m1;
            w_l2 = w_n0;
        end

        if (!i_scan || w_l1.vld) begin
            o_out = w_l0;
            n_p   = w_l1;
            n_q   = w_l2;
        end else begin
            o_out = '0;
            n_p   = w_l0;
            n_q   = '0;
        end

        n_info = r_info;
        if (w_hit_a) begin
            n_info.found   = 1'b1;
            n_info.addr    = i_e.start + HDR_ADDR;
            n_info.granted = w_n0.bytes;
        end else if (w_hit_f) begin
            n_info.found = 1'b1;
            if (i_e.is_free) begin
                n_info.dbl = 1'b1;
            end else begin
                n_info.granted = i_e.bytes;
            end
        end

        n_merge_next = r_merge_next;
        if (w_act) begin
            n_merge_next = w_hit_f && !i_e.is_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p.vld      <= 1'b0;
            r_q.vld      <= 1'b0;
            r_info.found <= 1'b0;
            r_info.dbl   <= 1'b0;
            r_merge_next <= 1'b0;
        end else if (i_start) begin
            r_p.vld      <= 1'b0;
            r_q.vld      <= 1'b0;
            r_info       <= '0;
            r_merge_next <= 1'b0;
        end else if (i_shift) begin
            r_p          <= n_p;
            r_q          <= n_q;
            r_info       <= n_info;
            r_merge_next <= n_merge_next;
        end
    end

    assign o_evt = '{
        split:  i_shift && w_hit_a && w_split,
        merge:  i_shift && w_merge,
        take:   i_shift && w_hit_a,
        give:   i_shift && w_hit_f && !i_e.is_free,
        amount: w_hit_a ? w_n0.bytes : i_e.bytes
    };
    assign o_info = r_info;
    assign o_pend = r_p.vld;

endmodule

[src/first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// Sequence: a scan of every ring slot, then draining the pending buffer and
// rotating the ring back to the arena head; a null request skips these steps
// and goes straight to S_DONE.
// Flow: one request at a time, bounded by the ring rotation. A stalled
// response holds the core in S_DONE.
// Reset: one free block spans the arena, the split margin is 32.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [47:0]      s_axis_tdata,  // request_size, free_address, zero pad
    input  logic             s_axis_tuser,  // command
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // address, granted_size, bytes_in_use,
                                            // block_count, zero pad
    output logic [STAT_W-1:0] m_axis_tuser  // status
);

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FLUSH = 5'b00100,
        S_ALIGN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_min;
    logic [IDX_W-1:0]  r_cnt;
    t_cmd              r_cmd;
    logic              r_null;
    logic [NEED_W-1:0] r_need, r_need_h;
    logic [ADDR_W-1:0] r_faddr;
    logic [THR_W-1:0]  r_thr;
    logic [CNT_W-1:0]  r_used;
    logic [ADDR_W-1:0] r_total;
    logic              r_m_vld;
    logic [71:0]       r_m_data;
    logic [STAT_W-1:0] r_m_user;

    t_entry            w_cell [MAX_BLOCKS];
    t_entry            w_out;
    t_evt              w_evt;
    t_info             w_info;
    t_req              w_req;
    t_status           w_status;
    logic              w_accept, w_shift, w_head, w_pend, w_load;
    logic [NEED_W-1:0] w_need;
    logic [ADDR_W-1:0] w_req_size, w_faddr;

    assign w_req_size = s_axis_tdata[20:0];
    assign w_faddr    = s_axis_tdata[41:21];
    assign w_need     = ({1'b0, w_req_size} + ALIGN_MSK) & ~ALIGN_MSK;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_head        = w_cell[0].vld && (w_cell[0].start == '0);
    assign w_load        = (r_state == S_DONE) && (!r_m_vld || m_axis_tready);

    always_comb begin
        w_shift = 1'b0;
        unique case (r_state)
            S_SCAN:  w_shift = 1'b1;
            S_FLUSH: w_shift = w_pend;
            S_ALIGN: w_shift = !w_head;
            default: w_shift = 1'b0;
        endcase
    end

    assign w_req = '{
        cmd:    r_cmd,
        need:   r_need,
        need_h: r_need_h,
        faddr:  r_faddr,
        thr:    r_thr,
        room:   r_used < CNT_W'(MAX_BLOCKS)
    };

    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        ffha_cell #(
            .IS_HEAD (k == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     ((k == MAX_BLOCKS - 1) ? w_out : w_cell[(k + 1) % MAX_BLOCKS]),
            .o_q     (w_cell[k])
        );
    end

    ffha_proc u_proc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_scan  (r_state == S_SCAN),
        .i_shift (w_shift),
        .i_req   (w_req),
        .i_e     (w_cell[0]),
        .o_out   (w_out),
        .o_evt   (w_evt),
        .o_info  (w_info),
        .o_pend  (w_pend)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = ((s_axis_tuser == CMD_ALLOC) ? (w_req_size == '0)
                                                           : (w_faddr == '0))
                              ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == IDX_W'(MAX_BLOCKS - 1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!w_pend) begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (w_head) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (r_null) begin
            w_status = ST_NULL;
        end else if (!w_info.found) begin
            w_status = (r_cmd == CMD_ALLOC) ? ST_OOM : ST_UNKNOWN;
        end else if (w_info.dbl) begin
            w_status = ST_DOUBLE;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min   <= CFG_W'(MIN_USEFUL_RESET);
            r_used  <= CNT_W'(1);
            r_total <= '0;
            r_m_vld <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_min <= i_cfg_wr_data;
            end
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_evt.split) begin
                r_used <= r_used + CNT_W'(1);
            end else if (w_evt.merge) begin
                r_used <= r_used - CNT_W'(1);
            end
            if (w_evt.take) begin
                r_total <= r_total + w_evt.amount;
            end else if (w_evt.give) begin
                r_total <= r_total - w_evt.amount;
            end
            if (w_load) begin
                r_m_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= t_cmd'(s_axis_tuser);
            r_null   <= (s_axis_tuser == CMD_ALLOC) ? (w_req_size == '0) : (w_faddr == '0);
            r_need   <= w_need;
            r_need_h <= w_need + HDR_NEED;
            r_faddr  <= w_faddr;
            r_thr    <= THR_W'(HEADER_BYTES) + THR_W'(r_min);
        end
        if (w_load) begin
            r_m_user <= w_status;
            r_m_data <= {2'b00, r_used, r_total,
                         (w_status == ST_OK) ? w_info.granted : '0,
                         (w_status == ST_OK && r_cmd == CMD_ALLOC) ? w_info.addr : '0};
        end
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> w_head)
        else $error("ring not aligned to arena head while idle");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_pend)
        else $error("pending buffer not drained while idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used >= CNT_W'(1)) && (r_used <= CNT_W'(MAX_BLOCKS)))
        else $error("block count out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

endmodule
